FILE: rtl/core/lsfb_pkg.sv
// Shared types and constants for the LED strip frame buffer and serializer.
`timescale 1ns / 1ps

package lsfb_pkg;

    localparam int MAX_PIXELS_DEF = 1024;
    localparam int CMD_W          = 3;
    localparam int IDX_W          = 10;
    localparam int CH_W           = 16;
    localparam int AMT_W          = 16;
    localparam int CNT_W          = 11;
    localparam int BRT_W          = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int PIX_W          = 3 * CH_W;
    localparam int POST_W         = CNT_W - 4;

    localparam logic [CNT_W-1:0] ACTIVE_RST = 11'd1024;
    localparam logic [BRT_W-1:0] BRT_RST    = 5'd31;
    localparam logic [CH_W-1:0]  END_WORD   = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR16    = 3'd0,
        CMD_WR8_REP = 3'd1,
        CMD_WR8_HI  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_ROT_L   = 3'd4,
        CMD_ROT_R   = 3'd5,
        CMD_START   = 3'd6,
        CMD_NEXT    = 3'd7
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE = 2'd0,
        CFG_BR_RED = 2'd1,
        CFG_BR_GRN = 2'd2,
        CFG_BR_BLU = 2'd3
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WORD,
        ST_DIV,
        ST_ROT,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_PIX,
        PH_POST
    } t_phase;

endpackage

FILE: rtl/core/lsfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module lsfb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lsfb_mod.sv
// Bit-serial remainder unit: rotate distance modulo the active pixel count.
`timescale 1ns / 1ps

module lsfb_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lsfb_pkg::AMT_W-1:0] i_dividend,
    input  logic [lsfb_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [lsfb_pkg::CNT_W-1:0] o_rem
);
    import lsfb_pkg::*;

    localparam int STEP_W = $clog2(AMT_W);

    logic              r_run;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [AMT_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W-1:0]  w_next;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem, r_dvd[AMT_W-1]};
        if (w_trial >= {1'b0, r_dsr}) begin
            w_next = CNT_W'(w_trial - {1'b0, r_dsr});
        end else begin
            w_next = w_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(AMT_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/led_strip_frame_buffer_serializer.sv
// Top level: pixel frame buffer in two ping-pong RAMs and the 16-bit frame serializer.
`timescale 1ns / 1ps

// Commands are taken when start is high and busy is low. Pixel writes, frame start and
// ignored commands complete without leaving idle. A next-word command passes through
// the word state (one RAM read) and its word appears on o_frame_word with o_word_strobe
// for exactly one cycle; the receiver must take it then. Clear sweeps the active RAM,
// one pixel a cycle, over all MAX_PIXELS entries. Rotate first finds the distance modulo
// the active pixel count in the remainder unit; if that is nonzero, it then copies all
// MAX_PIXELS entries into the other RAM and swaps the two.
// After reset the block runs a clearing pass over all entries with busy high;
// configuration writes are taken at any time and a frame latches them at its start.
module led_strip_frame_buffer_serializer #(
    parameter int MAX_PIXELS = lsfb_pkg::MAX_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lsfb_pkg::CMD_W-1:0]      i_cmd,
    input  logic [lsfb_pkg::IDX_W-1:0]      i_pixel_index,
    input  logic [lsfb_pkg::CH_W-1:0]       i_red_value,
    input  logic [lsfb_pkg::CH_W-1:0]       i_green_value,
    input  logic [lsfb_pkg::CH_W-1:0]       i_blue_value,
    input  logic [lsfb_pkg::AMT_W-1:0]      i_shift_amount,
    input  logic                            i_cfg_we,
    input  logic [lsfb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_word_strobe,
    output logic [lsfb_pkg::CH_W-1:0]       o_frame_word,
    output logic                            o_last_word
);
    import lsfb_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);

    // configuration
    logic [CNT_W-1:0] r_active;
    logic [BRT_W-1:0] r_br_red;
    logic [BRT_W-1:0] r_br_grn;
    logic [BRT_W-1:0] r_br_blu;

    // control
    t_state           r_state;
    t_state           n_state;
    logic             r_sel;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_src;
    logic             r_left;
    logic             r_wr_pend;
    logic [AW-1:0]    r_wr_addr;

    // frame
    logic             r_running;
    t_phase           r_phase;
    logic [1:0]       r_sub;
    logic [AW-1:0]    r_pix;
    logic [POST_W-1:0] r_post;
    logic [CNT_W-1:0] r_fcount;
    logic [CH_W-1:0]  r_header;

    // result
    logic             r_strobe;
    logic [CH_W-1:0]  r_word;
    logic             r_last;

    logic [CNT_W-1:0] w_eff;
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_idle_cmd;
    logic             w_wr_ok;
    logic [CH_W-1:0]  w_r;
    logic [CH_W-1:0]  w_g;
    logic [CH_W-1:0]  w_b;
    logic             w_div_start;
    logic             w_div_done;
    logic [CNT_W-1:0] w_rem;
    logic [CNT_W-1:0] w_shift;
    logic             w_in_act;
    logic [AW-1:0]    w_src;
    logic [AW-1:0]    w_raddr;
    logic             w_we_act;
    logic [AW-1:0]    w_wa_act;
    logic [PIX_W-1:0] w_wd_act;
    logic             w_we0;
    logic             w_we1;
    logic [AW-1:0]    w_wa0;
    logic [AW-1:0]    w_wa1;
    logic [PIX_W-1:0] w_wd0;
    logic [PIX_W-1:0] w_wd1;
    logic [PIX_W-1:0] w_rd0;
    logic [PIX_W-1:0] w_rd1;
    logic [PIX_W-1:0] w_rdata;
    logic [CH_W-1:0]  w_word;
    logic             w_last;

    assign w_eff = (32'(r_active) > 32'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : r_active;
    assign w_cmd = t_cmd'(i_cmd);
    assign busy = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_idle_cmd = w_accept && !r_running;
    assign w_wr_ok = w_idle_cmd && (w_cmd inside {CMD_WR16, CMD_WR8_REP, CMD_WR8_HI})
                     && (CNT_W'(i_pixel_index) < w_eff);
    assign w_div_start = w_idle_cmd && (w_cmd inside {CMD_ROT_L, CMD_ROT_R})
                         && (w_eff != '0);

    always_comb begin
        case (w_cmd)
            CMD_WR8_REP: begin
                w_r = {i_red_value[7:0], i_red_value[7:0]};
                w_g = {i_green_value[7:0], i_green_value[7:0]};
                w_b = {i_blue_value[7:0], i_blue_value[7:0]};
            end
            CMD_WR8_HI: begin
                w_r = {i_red_value[7:0], 8'h00};
                w_g = {i_green_value[7:0], 8'h00};
                w_b = {i_blue_value[7:0], 8'h00};
            end
            default: begin
                w_r = i_red_value;
                w_g = i_green_value;
                w_b = i_blue_value;
            end
        endcase
    end

    lsfb_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_shift_amount),
        .i_divisor  (w_eff),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // right rotation by s is left rotation by n - s
    assign w_shift = r_left ? w_rem : CNT_W'(w_eff - w_rem);

    // copy source: rotated inside the active range, straight through beyond it
    assign w_in_act = 32'(r_idx) < 32'(w_eff);
    assign w_src = w_in_act ? r_src : r_idx;
    assign w_raddr = (r_state == ST_ROT) ? w_src : r_pix;

    // writes into the active buffer: pixel writes and the clearing sweep
    always_comb begin
        w_we_act = 1'b0;
        w_wa_act = AW'(i_pixel_index);
        w_wd_act = {w_r, w_g, w_b};
        if (r_state == ST_CLEAR) begin
            w_we_act = 1'b1;
            w_wa_act = r_idx;
            w_wd_act = '0;
        end else if (w_wr_ok) begin
            w_we_act = 1'b1;
        end
    end

    assign w_rdata = r_sel ? w_rd1 : w_rd0;

    // rotation copy lands in the inactive buffer
    assign w_we0 = r_sel ? r_wr_pend : w_we_act;
    assign w_wa0 = r_sel ? r_wr_addr : w_wa_act;
    assign w_wd0 = r_sel ? w_rdata   : w_wd_act;
    assign w_we1 = r_sel ? w_we_act  : r_wr_pend;
    assign w_wa1 = r_sel ? w_wa_act  : r_wr_addr;
    assign w_wd1 = r_sel ? w_wd_act  : w_rdata;

    lsfb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_buf0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_wa0),
        .i_wdata (w_wd0),
        .i_raddr (w_raddr),
        .o_rdata (w_rd0)
    );

    lsfb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_buf1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_wa1),
        .i_wdata (w_wd1),
        .i_raddr (w_raddr),
        .o_rdata (w_rd1)
    );

    // word selection for a next-word command
    always_comb begin
        w_word = '0;
        w_last = 1'b0;
        case (r_phase)
            PH_PIX: begin
                case (r_sub)
                    2'd0:    w_word = r_header;
                    2'd1:    w_word = w_rdata[3*CH_W-1:2*CH_W];
                    2'd2:    w_word = w_rdata[2*CH_W-1:CH_W];
                    default: w_word = w_rdata[CH_W-1:0];
                endcase
            end
            PH_POST: begin
                w_word = END_WORD;
                w_last = (r_post == POST_W'(r_fcount >> 4));
            end
            default: w_word = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == CMD_NEXT) begin
                        if (r_running) begin
                            n_state = ST_WORD;
                        end
                    end else if (!r_running) begin
                        if (w_cmd == CMD_CLEAR) begin
                            n_state = ST_CLEAR;
                        end else if (w_div_start) begin
                            n_state = ST_DIV;
                        end
                    end
                end
            end
            ST_WORD: n_state = ST_IDLE;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = (w_rem == '0) ? ST_IDLE : ST_ROT;
                end
            end
            ST_ROT: begin
                if (r_idx == LAST_ADDR) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_br_red <= BRT_RST;
            r_br_grn <= BRT_RST;
            r_br_blu <= BRT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_idx))
                CFG_ACTIVE: r_active <= i_cfg_data;
                CFG_BR_RED: r_br_red <= i_cfg_data[BRT_W-1:0];
                CFG_BR_GRN: r_br_grn <= i_cfg_data[BRT_W-1:0];
                CFG_BR_BLU: r_br_blu <= i_cfg_data[BRT_W-1:0];
                default: ;
            endcase
        end
    end

    // sweep and frame control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
            r_running <= 1'b0;
            r_strobe  <= 1'b0;
            r_phase   <= PH_PRE;
            r_sub     <= '0;
            r_pix     <= '0;
            r_post    <= '0;
        end else begin
            r_strobe  <= 1'b0;
            r_wr_pend <= (r_state == ST_ROT);
            case (r_state)
                ST_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                end
                ST_IDLE: begin
                    r_idx <= '0;
                    if (w_idle_cmd && w_cmd == CMD_START) begin
                        r_running <= 1'b1;
                        r_phase   <= PH_PRE;
                        r_sub     <= '0;
                        r_pix     <= '0;
                        r_post    <= '0;
                    end
                end
                ST_WORD: begin
                    r_strobe <= 1'b1;
                    case (r_phase)
                        PH_PRE: begin
                            r_sub <= r_sub + 1'b1;
                            if (r_sub == 2'd3) begin
                                r_phase <= (r_fcount == '0) ? PH_POST : PH_PIX;
                            end
                        end
                        PH_PIX: begin
                            r_sub <= r_sub + 1'b1;
                            if (r_sub == 2'd3) begin
                                if (32'(r_pix) == 32'(r_fcount) - 32'd1) begin
                                    r_phase <= PH_POST;
                                end else begin
                                    r_pix <= r_pix + 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (w_last) begin
                                r_running <= 1'b0;
                            end else begin
                                r_post <= r_post + 1'b1;
                            end
                        end
                    endcase
                end
                ST_ROT: begin
                    r_idx <= r_idx + 1'b1;
                    if ((AW + 1)'({1'b0, r_src} + 1'b1) == (AW + 1)'(w_eff)) begin
                        r_src <= '0;
                    end else begin
                        r_src <= r_src + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    r_sel <= !r_sel;
                end
                default: ;
            endcase
            if (r_state == ST_DIV) begin
                r_src <= AW'(w_shift);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_left <= (w_cmd == CMD_ROT_L);
        end
        if (w_idle_cmd && w_cmd == CMD_START) begin
            r_fcount <= w_eff;
            r_header <= {1'b1, r_br_red, r_br_grn, r_br_blu};
        end
        if (r_state == ST_ROT) begin
            r_wr_addr <= r_idx;
        end
        if (r_state == ST_WORD) begin
            r_word <= w_word;
            r_last <= w_last;
        end
    end

    assign o_word_strobe = r_strobe;
    assign o_frame_word  = r_word;
    assign o_last_word   = r_strobe & r_last;

    // a word goes out only as the result of a next-word read
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_strobe |-> $past(r_state == ST_WORD))
        else $error("word strobe without a next-word read");

    // next-word reads happen only inside a running frame
    a_word_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORD) |-> r_running)
        else $error("next-word read outside a frame");

    // the final word ends the frame
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_word |-> (!r_running && r_phase == PH_POST))
        else $error("last word while frame still running");

    // a rotation copy never runs with an empty active range
    a_rot_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> (w_eff != '0))
        else $error("rotation with zero active pixels");

endmodule
